// ===== design/bilinear_table_interpolator_defines.svh =====
// assertion macros shared by the interpolator modules
// no dependencies; included by the controller and the datapath
`ifndef BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BTI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear interpolator check failed");

// consequent must hold in the cycle after the antecedent
`define BTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear interpolator check failed");

`endif

// ===== design/bti_pkg.sv =====
// types, codes and sizes of the bilinear table interpolator
// no dependencies; imported by every module of the block
package bti_pkg;

    // table geometry
    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 32;
    localparam int ROW_AW     = $clog2(MAX_ROWS);
    localparam int COL_AW     = $clog2(MAX_COLS);
    localparam int GRID_AW    = ROW_AW + COL_AW;
    localparam int MIN_IN_USE = 2;
    localparam int SRCH_STEPS = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IDX_W      = $clog2(SRCH_STEPS);

    // configuration registers
    localparam int ROWS_W = 5;
    localparam int COLS_W = 6;
    localparam int CFG_DW = 6;
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_COLS = 1'd1;

    // arithmetic sizes
    localparam int DW        = 32;
    localparam int FRAC      = 16;
    localparam int DIFF_W    = DW + 1;
    localparam int NUM_W     = DW + FRAC;
    localparam int DIV_STEPS = NUM_W;
    localparam int TW        = NUM_W + 2;
    localparam int VW        = 50;
    localparam int MW        = 50;
    localparam int MUL_STEPS = MW;
    localparam int PW        = 2 * MW;
    localparam int SAT_W     = 64;
    localparam int CNT_W     = $clog2(MUL_STEPS + 1);
    localparam int SEL_W     = 2;

    // item actions
    localparam logic [1:0] ACT_WR_ROW  = 2'd0;
    localparam logic [1:0] ACT_WR_COL  = 2'd1;
    localparam logic [1:0] ACT_WR_GRID = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_SRCH     = 4'd1;
    localparam logic [OP_W-1:0] OP_BRK_LO   = 4'd2;
    localparam logic [OP_W-1:0] OP_BRK_HI   = 4'd3;
    localparam logic [OP_W-1:0] OP_BRK_CAP  = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV_END  = 4'd7;
    localparam logic [OP_W-1:0] OP_GRID     = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_INIT = 4'd9;
    localparam logic [OP_W-1:0] OP_MUL_STEP = 4'd10;
    localparam logic [OP_W-1:0] OP_MUL_END  = 4'd11;
    localparam logic [OP_W-1:0] OP_OUT      = 4'd12;

    // divider axis and lerp selectors
    localparam logic [SEL_W-1:0] SEL_ROW  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_COL  = 2'd1;
    localparam logic [SEL_W-1:0] LERP_TOP = 2'd0;
    localparam logic [SEL_W-1:0] LERP_BOT = 2'd1;
    localparam logic [SEL_W-1:0] LERP_OUT = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [3:0]           row_index;
        logic [4:0]           col_index;
        logic signed [31:0]   write_data;
        logic signed [31:0]   arg_row;
        logic signed [31:0]   arg_col;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic             accept;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic degen;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/bilinear_table_interpolator.sv =====
// top level of the bilinear table interpolator
// depends on bti_pkg, bti_ctrl and bti_dp
//
//  transfer      valid     stall     payload
//  item in       i_valid   o_stall   i_in  (t_in)
//  result out    o_valid   i_stall   o_out (t_out)
//  config write  i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// a table write does not stall the input; a query runs a breakpoint scan, two 48-step
// restoring divisions and three 50-step shift-add multiplies, on one shared unit
// each; a degenerate interval skips the divisions and multiplies and ends after the check
// one item is in flight at a time; o_stall is high from query accept to result load
// a stalled result holds in the output register; reset is synchronous, active low
module bilinear_table_interpolator
    import bti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    bti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_in.action),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    // tables and arithmetic
    bti_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out)
    );

endmodule

// ===== design/bti_ctrl.sv =====
// sequencer of the interpolator: accepts items and steps the datapath
// depends on bti_pkg and the assertion macro header
`include "bilinear_table_interpolator_defines.svh"

module bti_ctrl
    import bti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    output logic       o_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_stat   i_stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_SWAIT = 4'd2;
    localparam logic [3:0] S_BLO   = 4'd3;
    localparam logic [3:0] S_BHI   = 4'd4;
    localparam logic [3:0] S_BCAP  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIVS  = 4'd8;
    localparam logic [3:0] S_DIVE  = 4'd9;
    localparam logic [3:0] S_GRID  = 4'd10;
    localparam logic [3:0] S_GWAIT = 4'd11;
    localparam logic [3:0] S_MULI  = 4'd12;
    localparam logic [3:0] S_MULS  = 4'd13;
    localparam logic [3:0] S_MULE  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SEL_W-1:0] r_sel, n_sel;

    // input side is open only between queries
    assign o_stall = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_sel        = r_sel;
        o_cmd.accept = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.idx    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid && (i_action == ACT_QUERY)) begin
                    n_state = S_SRCH;
                    n_cnt   = '0;
                end
            end
            S_SRCH: begin
                o_cmd.op  = OP_SRCH;
                o_cmd.idx = r_cnt[IDX_W-1:0];
                if (r_cnt == CNT_W'(SRCH_STEPS - 1)) begin
                    n_state = S_SWAIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_SWAIT: n_state = S_BLO;
            S_BLO: begin
                o_cmd.op = OP_BRK_LO;
                n_state  = S_BHI;
            end
            S_BHI: begin
                o_cmd.op = OP_BRK_HI;
                n_state  = S_BCAP;
            end
            S_BCAP: begin
                o_cmd.op = OP_BRK_CAP;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_stat.degen) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIVI;
                    n_sel   = SEL_ROW;
                end
            end
            S_DIVI: begin
                o_cmd.op  = OP_DIV_INIT;
                o_cmd.idx = IDX_W'(r_sel);
                n_cnt     = '0;
                n_state   = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DIVE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DIVE: begin
                o_cmd.op  = OP_DIV_END;
                o_cmd.idx = IDX_W'(r_sel);
                if (r_sel == SEL_ROW) begin
                    n_sel   = SEL_COL;
                    n_state = S_DIVI;
                end else begin
                    n_cnt   = '0;
                    n_state = S_GRID;
                end
            end
            S_GRID: begin
                o_cmd.op  = OP_GRID;
                o_cmd.idx = r_cnt[IDX_W-1:0];
                if (r_cnt == CNT_W'(3)) begin
                    n_state = S_GWAIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_GWAIT: begin
                n_sel   = LERP_TOP;
                n_state = S_MULI;
            end
            S_MULI: begin
                o_cmd.op  = OP_MUL_INIT;
                o_cmd.idx = IDX_W'(r_sel);
                n_cnt     = '0;
                n_state   = S_MULS;
            end
            S_MULS: begin
                o_cmd.op = OP_MUL_STEP;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_MULE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MULE: begin
                o_cmd.op  = OP_MUL_END;
                o_cmd.idx = IDX_W'(r_sel);
                if (r_sel == LERP_OUT) begin
                    n_state = S_OUT;
                end else begin
                    n_sel   = r_sel + SEL_W'(1);
                    n_state = S_MULI;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    `BTI_ASSERT_NEXT(a_query_starts_search, i_clk, i_rst_n, (r_state == S_IDLE) && i_valid && (i_action == ACT_QUERY), r_state == S_SRCH)
    `BTI_ASSERT_SAME(a_div_count_bound, i_clk, i_rst_n, r_state == S_DIVS, r_cnt < CNT_W'(DIV_STEPS))
    `BTI_ASSERT_SAME(a_lerp_sel_bound, i_clk, i_rst_n, (r_state == S_MULI) || (r_state == S_MULS) || (r_state == S_MULE), r_sel <= LERP_OUT)

endmodule

// ===== design/bti_dp.sv =====
// datapath: table memories, interval search, serial divider and multiplier
// depends on bti_pkg and the assertion macro header
`include "bilinear_table_interpolator_defines.svh"

module bti_dp
    import bti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  t_in               i_in,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_out
);

    localparam logic signed [SAT_W-1:0] SMAX64 = {1'b0, {(SAT_W-1){1'b1}}};
    localparam logic signed [VW-1:0] VMAX = {{(VW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {{(VW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    // configuration and clamped counts
    logic [ROWS_W-1:0] r_rows, nr, nr_m2, cnt_rm1;
    logic [COLS_W-1:0] r_cols, nc, nc_m2, cnt_cm1;

    // memories and registered read data
    logic signed [DW-1:0] r_row_mem  [MAX_ROWS];
    logic signed [DW-1:0] r_col_mem  [MAX_COLS];
    logic signed [DW-1:0] r_grid_mem [MAX_ROWS * MAX_COLS];
    logic signed [DW-1:0] r_row_q, r_col_q, r_grid_q;
    logic [ROW_AW-1:0]    row_addr, grid_row;
    logic [COL_AW-1:0]    col_addr, grid_col;

    // query registers
    logic signed [DW-1:0] r_arg_r, r_arg_c, r_r0, r_r1, r_c0, r_c1;
    logic signed [DW-1:0] r_g00, r_g01, r_g10, r_g11;
    logic [ROWS_W-1:0]    r_cnt_r;
    logic [COLS_W-1:0]    r_cnt_c;
    logic [ROW_AW-1:0]    r_i, w_i;
    logic [COL_AW-1:0]    r_j, w_j;
    logic                 r_sval, r_gval;
    logic [IDX_W-1:0]     r_sidx;
    logic [1:0]           r_gidx;

    // divider
    logic signed [DIFF_W-1:0] d_num, d_den, d_num_neg, d_den_neg;
    logic [DW-1:0]            d_num_mag, d_den_mag;
    logic [NUM_W-1:0]         r_dq;
    logic [DW-1:0]            r_rem, r_dvs;
    logic                     r_dneg;
    logic [DW:0]              d_trial, d_sub;
    logic signed [TW-1:0]     d_qext, d_t, r_tr, r_tc;

    // multiplier and lerp
    logic signed [VW-1:0]    m_a, m_b, m_d, r_la, r_top, r_bot, r_v;
    logic signed [TW-1:0]    m_t;
    logic [MW-1:0]           m_dmag, m_tmag, r_mcand;
    logic [PW-1:0]           r_prod;
    logic                    r_mneg, r_ov, m_ovf;
    logic [MW:0]             m_sum;
    logic signed [SAT_W-1:0] m_pmag, m_sval;
    logic signed [VW-1:0]    m_shx, m_res;

    // output register
    logic r_out_valid;
    t_out r_out;
    logic degen;

    // clamp the in-use counts
    always_comb begin
        if (r_rows < ROWS_W'(MIN_IN_USE)) begin
            nr = ROWS_W'(MIN_IN_USE);
        end else if (r_rows > ROWS_W'(MAX_ROWS)) begin
            nr = ROWS_W'(MAX_ROWS);
        end else begin
            nr = r_rows;
        end
        if (r_cols < COLS_W'(MIN_IN_USE)) begin
            nc = COLS_W'(MIN_IN_USE);
        end else if (r_cols > COLS_W'(MAX_COLS)) begin
            nc = COLS_W'(MAX_COLS);
        end else begin
            nc = r_cols;
        end
    end

    // interval index from the below-argument counts
    assign nr_m2   = nr - ROWS_W'(MIN_IN_USE);
    assign nc_m2   = nc - COLS_W'(MIN_IN_USE);
    assign cnt_rm1 = r_cnt_r - ROWS_W'(1);
    assign cnt_cm1 = r_cnt_c - COLS_W'(1);
    assign w_i = (r_cnt_r == ROWS_W'(0)) ? ROW_AW'(0) :
                 (cnt_rm1 > nr_m2) ? nr_m2[ROW_AW-1:0] : cnt_rm1[ROW_AW-1:0];
    assign w_j = (r_cnt_c == COLS_W'(0)) ? COL_AW'(0) :
                 (cnt_cm1 > nc_m2) ? nc_m2[COL_AW-1:0] : cnt_cm1[COL_AW-1:0];

    // memory read addresses
    always_comb begin
        row_addr = i_cmd.idx[ROW_AW-1:0];
        col_addr = i_cmd.idx[COL_AW-1:0];
        case (i_cmd.op)
            OP_BRK_LO: begin
                row_addr = w_i;
                col_addr = w_j;
            end
            OP_BRK_HI: begin
                row_addr = r_i + ROW_AW'(1);
                col_addr = r_j + COL_AW'(1);
            end
            default: ;
        endcase
    end
    assign grid_row = r_i + ROW_AW'(i_cmd.idx[1]);
    assign grid_col = r_j + COL_AW'(i_cmd.idx[0]);

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in.action == ACT_WR_ROW)) begin
            r_row_mem[i_in.row_index] <= i_in.write_data;
        end
        r_row_q <= r_row_mem[row_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in.action == ACT_WR_COL)) begin
            r_col_mem[i_in.col_index] <= i_in.write_data;
        end
        r_col_q <= r_col_mem[col_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in.action == ACT_WR_GRID)) begin
            r_grid_mem[{i_in.row_index, i_in.col_index}] <= i_in.write_data;
        end
        r_grid_q <= r_grid_mem[{grid_row, grid_col}];
    end

    // divider operands
    always_comb begin
        if (i_cmd.idx[SEL_W-1:0] == SEL_ROW) begin
            d_num = {r_arg_r[DW-1], r_arg_r} - {r_r0[DW-1], r_r0};
            d_den = {r_r1[DW-1], r_r1} - {r_r0[DW-1], r_r0};
        end else begin
            d_num = {r_arg_c[DW-1], r_arg_c} - {r_c0[DW-1], r_c0};
            d_den = {r_c1[DW-1], r_c1} - {r_c0[DW-1], r_c0};
        end
        d_num_neg = -d_num;
        d_den_neg = -d_den;
        d_num_mag = d_num[DIFF_W-1] ? d_num_neg[DW-1:0] : d_num[DW-1:0];
        d_den_mag = d_den[DIFF_W-1] ? d_den_neg[DW-1:0] : d_den[DW-1:0];
    end

    // one restoring division step, and the floored quotient
    assign d_trial = {r_rem, r_dq[NUM_W-1]};
    assign d_sub   = d_trial - {1'b0, r_dvs};
    assign d_qext  = {{(TW-NUM_W){1'b0}}, r_dq};
    assign d_t     = r_dneg ? (-d_qext - TW'(r_rem != '0)) : d_qext;

    // lerp operands
    always_comb begin
        case (i_cmd.idx[SEL_W-1:0])
            LERP_TOP: begin
                m_a = {{(VW-DW){r_g00[DW-1]}}, r_g00};
                m_b = {{(VW-DW){r_g01[DW-1]}}, r_g01};
                m_t = r_tc;
            end
            LERP_BOT: begin
                m_a = {{(VW-DW){r_g10[DW-1]}}, r_g10};
                m_b = {{(VW-DW){r_g11[DW-1]}}, r_g11};
                m_t = r_tc;
            end
            default: begin
                m_a = r_top;
                m_b = r_bot;
                m_t = r_tr;
            end
        endcase
        m_d    = m_b - m_a;
        m_dmag = m_d[VW-1] ? MW'(-m_d) : MW'(m_d);
        m_tmag = m_t[TW-1] ? MW'(-m_t) : MW'(m_t);
    end

    // shift-add step, then saturate, scale and add the base
    assign m_sum  = {1'b0, r_prod[PW-1:MW]} + {1'b0, r_mcand};
    assign m_ovf  = |r_prod[PW-1:SAT_W-1];
    assign m_pmag = {1'b0, r_prod[SAT_W-2:0]};
    assign m_sval = m_ovf ? (r_mneg ? -SMAX64 : SMAX64) : (r_mneg ? -m_pmag : m_pmag);
    assign m_shx  = {{(VW-SAT_W+FRAC){m_sval[SAT_W-1]}}, m_sval[SAT_W-1:FRAC]};
    assign m_res  = r_la + m_shx;

    assign degen = (r_r1 == r_r0) || (r_c1 == r_c0);

    // query datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_arg_r <= i_in.arg_row;
            r_arg_c <= i_in.arg_col;
            r_cnt_r <= '0;
            r_cnt_c <= '0;
            r_ov    <= 1'b0;
        end
        // breakpoint compare, one read behind the address
        if (r_sval) begin
            if ((r_sidx < nr) && (r_arg_r > r_row_q)) begin
                r_cnt_r <= r_cnt_r + ROWS_W'(1);
            end
            if (({1'b0, r_sidx} < nc) && (r_arg_c > r_col_q)) begin
                r_cnt_c <= r_cnt_c + COLS_W'(1);
            end
        end
        // corner capture
        if (r_gval) begin
            case (r_gidx)
                2'd0:    r_g00 <= r_grid_q;
                2'd1:    r_g01 <= r_grid_q;
                2'd2:    r_g10 <= r_grid_q;
                default: r_g11 <= r_grid_q;
            endcase
        end
        r_sidx <= i_cmd.idx;
        r_gidx <= i_cmd.idx[1:0];
        unique case (i_cmd.op)
            OP_BRK_LO: begin
                r_i <= w_i;
                r_j <= w_j;
            end
            OP_BRK_HI: begin
                r_r0 <= r_row_q;
                r_c0 <= r_col_q;
            end
            OP_BRK_CAP: begin
                r_r1 <= r_row_q;
                r_c1 <= r_col_q;
            end
            OP_DIV_INIT: begin
                r_dq   <= {d_num_mag, {FRAC{1'b0}}};
                r_rem  <= '0;
                r_dvs  <= d_den_mag;
                r_dneg <= d_num[DIFF_W-1] ^ d_den[DIFF_W-1];
            end
            OP_DIV_STEP: begin
                if (!d_sub[DW]) begin
                    r_rem <= d_sub[DW-1:0];
                    r_dq  <= {r_dq[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= d_trial[DW-1:0];
                    r_dq  <= {r_dq[NUM_W-2:0], 1'b0};
                end
            end
            OP_DIV_END: begin
                if (i_cmd.idx[SEL_W-1:0] == SEL_ROW) begin
                    r_tr <= d_t;
                end else begin
                    r_tc <= d_t;
                end
            end
            OP_MUL_INIT: begin
                r_la    <= m_a;
                r_mcand <= m_dmag;
                r_prod  <= {{MW{1'b0}}, m_tmag};
                r_mneg  <= m_d[VW-1] ^ m_t[TW-1];
            end
            OP_MUL_STEP: begin
                if (r_prod[0]) begin
                    r_prod <= {m_sum, r_prod[MW-1:1]};
                end else begin
                    r_prod <= {1'b0, r_prod[PW-1:1]};
                end
            end
            OP_MUL_END: begin
                r_ov <= r_ov | m_ovf;
                case (i_cmd.idx[SEL_W-1:0])
                    LERP_TOP: r_top <= m_res;
                    LERP_BOT: r_bot <= m_res;
                    default:  r_v   <= m_res;
                endcase
            end
            OP_NONE, OP_SRCH, OP_GRID, OP_OUT: ;
            default: ;
        endcase
    end

    // final saturation into the result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            if (degen) begin
                r_out.value  <= '0;
                r_out.status <= ST_DEGEN;
            end else if (r_v > VMAX) begin
                r_out.value  <= VMAX[DW-1:0];
                r_out.status <= ST_SAT;
            end else if (r_v < VMIN) begin
                r_out.value  <= VMIN[DW-1:0];
                r_out.status <= ST_SAT;
            end else begin
                r_out.value  <= r_v[DW-1:0];
                r_out.status <= r_ov ? ST_SAT : ST_OK;
            end
        end
    end

    // control registers: configuration, read-valid flags, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= ROWS_W'(MIN_IN_USE);
            r_cols      <= COLS_W'(MIN_IN_USE);
            r_sval      <= 1'b0;
            r_gval      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS: r_rows <= i_cfg_data[ROWS_W-1:0];
                    CFG_COLS: r_cols <= i_cfg_data[COLS_W-1:0];
                    default: ;
                endcase
            end
            r_sval <= (i_cmd.op == OP_SRCH);
            r_gval <= (i_cmd.op == OP_GRID);
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out          = r_out;
    assign o_stat.degen   = degen;
    assign o_stat.out_free = !r_out_valid || !i_stall;

    `BTI_ASSERT_NEXT(a_row_interval_bound, i_clk, i_rst_n, i_cmd.op == OP_BRK_LO, ({1'b0, r_i} + ROWS_W'(MIN_IN_USE)) <= nr)
    `BTI_ASSERT_SAME(a_degen_value_zero, i_clk, i_rst_n, r_out_valid && (r_out.status == ST_DEGEN), r_out.value == '0)
    `BTI_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid && $stable(r_out))

endmodule
